>>> rtl/csl_pkg.sv
// ============================================================================
// csl_pkg - shared types and constants for the clock sync lock monitor
// Item layouts, register defaults and lock state encodings.
// ============================================================================
`default_nettype none

package csl_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_OWN_MAC      = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COARSE_THR   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FINE_THR     = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STABLE_POLLS = 8'd3;

    localparam logic [47:0] OWN_MAC_RESET      = 48'd0;
    localparam logic [31:0] COARSE_THR_RESET   = 32'd10_000_000;
    localparam logic [31:0] FINE_THR_RESET     = 32'd1000;
    localparam logic [7:0]  STABLE_POLLS_RESET = 8'd4;

    // Bytes FF FE inserted into the MAC to form the EUI-64
    localparam logic [15:0] EUI_FILL = 16'hFFFE;

    localparam logic [7:0] STABLE_CNT_MAX = 8'hFF;

    // Reported lock state codes
    localparam logic [1:0] LOCK_CODE_UNLOCKED = 2'd0;
    localparam logic [1:0] LOCK_CODE_LOCKING  = 2'd1;
    localparam logic [1:0] LOCK_CODE_LOCKED   = 2'd2;

    // Input item function codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_STOP = 1'b1;

    typedef enum logic [2:0] {
        ST_UNLOCKED = 3'b001,
        ST_LOCKING  = 3'b010,
        ST_LOCKED   = 3'b100
    } lock_t;

    typedef struct packed {
        logic               func;
        logic               status_ok;
        logic signed [63:0] clk_offset;
        logic signed [31:0] mean_delay;
        logic               source_valid;
        logic [63:0]        master_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         lock_status;
        logic               state_changed;
        logic               self_master;
        logic [63:0]        reported_master_id;
        logic signed [31:0] cached_offset;
        logic signed [31:0] cached_delay_ns;
    } out_item_t;

    // Decoded item control handed to the lock state machine
    typedef struct packed {
        logic update;    // item leaves the pipe this cycle
        logic stop;      // stop event
        logic poll_ok;   // successful poll
        logic self_gm;   // node is its own grandmaster
        logic lost;      // |offset| >= coarse threshold
        logic fine;      // |offset| <  fine threshold
    } lock_ctl_t;

    typedef struct packed {
        logic [1:0] lock_code_next;  // lock state after this item
        logic       changed;         // this item changes the lock state
        logic       locked;          // lock state before this item is LOCKED
    } lock_sts_t;

    function automatic logic [1:0] lock_code(input lock_t st);
        logic [1:0] code;
        unique case (st)
            ST_LOCKING: code = LOCK_CODE_LOCKING;
            ST_LOCKED:  code = LOCK_CODE_LOCKED;
            default:    code = LOCK_CODE_UNLOCKED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/csl_lock_fsm.sv
// ============================================================================
// csl_lock_fsm - unlocked / locking / locked state machine
// Holds lock state and stable poll counter, updated once per item.
// ============================================================================
`default_nettype none

module csl_lock_fsm (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire csl_pkg::lock_ctl_t ctl,
    input  wire logic [7:0]        stable_polls_needed,
    output      csl_pkg::lock_sts_t sts
);
    import csl_pkg::*;

    lock_t      lock_reg, lock_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] cnt_inc;

    assign cnt_inc = (cnt_reg == STABLE_CNT_MAX) ? cnt_reg : cnt_reg + 8'd1;

    always_comb begin
        lock_next = lock_reg;
        cnt_next  = cnt_reg;
        if (ctl.stop) begin
            lock_next = ST_UNLOCKED;
            cnt_next  = '0;
        end else if (ctl.poll_ok && ctl.self_gm) begin
            // own grandmaster: force locked, leave the counter alone
            lock_next = ST_LOCKED;
        end else if (ctl.poll_ok) begin
            unique case (lock_reg)
                ST_LOCKING: begin
                    if (ctl.lost) begin
                        lock_next = ST_UNLOCKED;
                        cnt_next  = '0;
                    end else if (ctl.fine) begin
                        cnt_next = cnt_inc;
                        if (cnt_inc >= stable_polls_needed) begin
                            lock_next = ST_LOCKED;
                        end
                    end else begin
                        cnt_next = '0;
                    end
                end
                ST_LOCKED: begin
                    if (ctl.lost) begin
                        lock_next = ST_UNLOCKED;
                        cnt_next  = '0;
                    end else if (!ctl.fine) begin
                        lock_next = ST_LOCKING;
                        cnt_next  = '0;
                    end
                end
                default: begin
                    lock_next = ST_UNLOCKED;
                    if (!ctl.lost) begin
                        lock_next = ST_LOCKING;
                        cnt_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg <= ST_UNLOCKED;
            cnt_reg  <= '0;
        end else if (ctl.update) begin
            lock_reg <= lock_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign sts.lock_code_next = lock_code(lock_next);
    assign sts.changed        = (lock_next != lock_reg);
    assign sts.locked         = (lock_reg == ST_LOCKED);

    // Stop event always lands in unlocked with a clear counter
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.update && ctl.stop |=> lock_reg == ST_UNLOCKED && cnt_reg == '0)
        else $error("stop event did not clear lock state");

    // Own-grandmaster poll always ends locked
    a_self_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.update && !ctl.stop && ctl.poll_ok && ctl.self_gm |=> lock_reg == ST_LOCKED)
        else $error("self grandmaster poll did not lock");

    // Lost sync from a tracked master always drops to unlocked
    a_lost_unlocks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.update && !ctl.stop && ctl.poll_ok && !ctl.self_gm && ctl.lost
        |=> lock_reg == ST_UNLOCKED && cnt_reg == '0)
        else $error("lost sync did not unlock");

endmodule

`default_nettype wire

>>> rtl/clock_sync_lock_monitor.sv
// Flow: an accepted item is registered in the input register and then in the result
// register, where m_valid rises for it.
// Throughput: one item per cycle; s_ready falls only while both registers hold
// items and m_ready is low.
// Reset: aresetn low at a clock edge clears both stages, lock state, counter, identity
// and cached values, and reloads the register defaults.
// ============================================================================
// clock_sync_lock_monitor - time sync lock detector
// Tracks grandmaster identity and clock offset and reports lock status per item.
// ============================================================================
`default_nettype none

module clock_sync_lock_monitor (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [csl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [csl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input item channel
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire csl_pkg::in_item_t             s_item,
    // result item channel
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      csl_pkg::out_item_t            m_item
);
    import csl_pkg::*;

    // Item after the front-end decode: magnitude compares and identity match
    // are done before the input register so that the state update is short.
    typedef struct packed {
        logic        func;
        logic        status_ok;
        logic        self_gm;
        logic        lost;
        logic        fine;
        logic [31:0] offset_lo;
        logic [31:0] delay;
        logic [63:0] master_id;
    } pipe_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] own_mac_reg;
    logic [31:0] coarse_thr_reg;
    logic [31:0] fine_thr_reg;
    logic [7:0]  stable_polls_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg      <= OWN_MAC_RESET;
            coarse_thr_reg   <= COARSE_THR_RESET;
            fine_thr_reg     <= FINE_THR_RESET;
            stable_polls_reg <= STABLE_POLLS_RESET;
        end else if (cfg_wr_en) begin
            // indexes past the last register are dropped
            unique case (cfg_addr)
                REG_OWN_MAC:      own_mac_reg      <= cfg_wdata[47:0];
                REG_COARSE_THR:   coarse_thr_reg   <= cfg_wdata[31:0];
                REG_FINE_THR:     fine_thr_reg     <= cfg_wdata[31:0];
                REG_STABLE_POLLS: stable_polls_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // EUI-64: MAC with FF FE inserted after the third byte
    logic [63:0] own_eui;
    assign own_eui = {own_mac_reg[47:24], EUI_FILL, own_mac_reg[23:0]};

    // ------------------------------------------------------------------
    // Front-end decode of the incoming item
    // ------------------------------------------------------------------
    logic [63:0] off_raw;
    logic [62:0] off_neg;
    logic [62:0] off_mag;
    pipe_t       pipe_next;

    assign off_raw = s_item.clk_offset;
    assign off_neg = ~off_raw[62:0] + 63'd1;

    always_comb begin
        // most negative offset saturates to the largest positive magnitude
        if (off_raw[63] && (off_raw[62:0] == '0)) begin
            off_mag = '1;
        end else if (off_raw[63]) begin
            off_mag = off_neg;
        end else begin
            off_mag = off_raw[62:0];
        end
    end

    always_comb begin
        pipe_next.func      = s_item.func;
        pipe_next.status_ok = s_item.status_ok;
        pipe_next.self_gm   = !s_item.source_valid || (s_item.master_id == own_eui);
        pipe_next.lost      = (off_mag[62:32] != '0) || (off_mag[31:0] >= coarse_thr_reg);
        pipe_next.fine      = (off_mag[62:32] == '0) && (off_mag[31:0] < fine_thr_reg);
        pipe_next.offset_lo = off_raw[31:0];
        pipe_next.delay     = s_item.mean_delay;
        pipe_next.master_id = s_item.master_id;
    end

    // ------------------------------------------------------------------
    // Input register and result register handshake
    // ------------------------------------------------------------------
    logic  pipe_valid_reg;
    pipe_t pipe_reg;
    logic  m_valid_reg;
    logic  out_free;
    logic  advance;

    // result register takes a new item when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = pipe_valid_reg && out_free;
    assign s_ready  = !pipe_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
        end else if (s_ready) begin
            pipe_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            pipe_reg <= pipe_next;
        end
    end

    // ------------------------------------------------------------------
    // Lock state machine
    // ------------------------------------------------------------------
    lock_ctl_t lock_ctl;
    lock_sts_t lock_sts;

    assign lock_ctl.update  = advance;
    assign lock_ctl.stop    = (pipe_reg.func == FUNC_STOP);
    assign lock_ctl.poll_ok = (pipe_reg.func == FUNC_POLL) && pipe_reg.status_ok;
    assign lock_ctl.self_gm = pipe_reg.self_gm;
    assign lock_ctl.lost    = pipe_reg.lost;
    assign lock_ctl.fine    = pipe_reg.fine;

    csl_lock_fsm u_lock_fsm (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .ctl                 (lock_ctl),
        .stable_polls_needed (stable_polls_reg),
        .sts                 (lock_sts)
    );

    // ------------------------------------------------------------------
    // Master identity and cached measurements
    // ------------------------------------------------------------------
    logic        self_flag_reg, self_flag_next;
    logic [63:0] stored_id_reg, stored_id_next;
    logic [31:0] off_cache_reg, off_cache_next;
    logic [31:0] dly_cache_reg, dly_cache_next;

    always_comb begin
        self_flag_next = self_flag_reg;
        stored_id_next = stored_id_reg;
        off_cache_next = off_cache_reg;
        dly_cache_next = dly_cache_reg;
        if (lock_ctl.stop) begin
            // stop keeps the identity, drops the measurements
            off_cache_next = '0;
            dly_cache_next = '0;
        end else if (lock_ctl.poll_ok) begin
            self_flag_next = pipe_reg.self_gm;
            stored_id_next = pipe_reg.master_id;
            if (pipe_reg.self_gm && !lock_sts.locked) begin
                // zero the measurements on the move to self grandmaster lock
                off_cache_next = '0;
                dly_cache_next = '0;
            end else begin
                off_cache_next = pipe_reg.offset_lo;
                dly_cache_next = pipe_reg.delay;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_flag_reg <= 1'b0;
            stored_id_reg <= '0;
            off_cache_reg <= '0;
            dly_cache_reg <= '0;
        end else if (advance) begin
            self_flag_reg <= self_flag_next;
            stored_id_reg <= stored_id_next;
            off_cache_reg <= off_cache_next;
            dly_cache_reg <= dly_cache_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    out_item_t m_item_reg, m_item_next;

    always_comb begin
        m_item_next.lock_status        = lock_sts.lock_code_next;
        m_item_next.state_changed      = lock_sts.changed;
        m_item_next.self_master        = self_flag_next;
        m_item_next.reported_master_id = self_flag_next ? own_eui : stored_id_next;
        m_item_next.cached_offset      = off_cache_next;
        m_item_next.cached_delay_ns    = dly_cache_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= pipe_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Input stalls only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> pipe_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a full pipe");

    // An item leaving the input register always shows up as a result
    a_item_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced item lost before the result register");

    // A stop event reports unlocked with cleared measurements
    a_stop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && lock_ctl.stop
        |=> m_item_reg.lock_status == LOCK_CODE_UNLOCKED
            && m_item_reg.cached_offset == '0 && m_item_reg.cached_delay_ns == '0)
        else $error("stop event result not cleared");

endmodule

`default_nettype wire
